[sv/lzfbd_pkg.sv]
// Shared types and constants for the LZSS flag-byte decompressor.
package lzfbd_pkg;

   localparam int unsigned DIST_BITS = 12;
   localparam logic [15:0] DIST_MASK = 16'h0FFF;
   localparam logic [7:0] LEN_BIAS = 8'd3;
   localparam logic [2:0] LAST_FLAG = 3'd7;
   localparam logic [3:0] ESC_NIBBLE = 4'hF;
   localparam logic [2:0] PACK_LAST_SLOT = 3'd3;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
      logic [7:0] out_byte3;
      logic [2:0] byte_count;
      logic       run_end;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic load_flags;
      logic load_low;
      logic load_hi;
      logic load_len;
      logic zero_remain;
      logic lit_put;
      logic rd_issue;
      logic wr_put;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [7:0] flag_bits;
      logic       escape;
      logic       len_zero;
      logic       fin;
      logic [2:0] pack_count;
      logic       remain_one;
      logic       remain_zero;
      logic       out_free;
   } stat_type;

endpackage

[sv/lzfbd_ctrl.sv]
// Controller: stream parser and the sequencer for literal, copy and emit steps.
module lzfbd_ctrl import lzfbd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LIT  = 3'd1;
   localparam logic [2:0] ST_RD   = 3'd2;
   localparam logic [2:0] ST_WR   = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   localparam logic [1:0] PH_FLAG  = 2'd0;
   localparam logic [1:0] PH_TOKEN = 2'd1;
   localparam logic [1:0] PH_HIGH  = 2'd2;
   localparam logic [1:0] PH_LEN   = 2'd3;

   logic [2:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [2:0] index_ff, index_in;
   logic [2:0] done_index;
   logic [1:0] done_phase;

   assign req_stall = reset || (state_ff != ST_IDLE);

   // Parser position once the current token is complete.
   always_comb begin
      if (index_ff == LAST_FLAG) begin
         done_index = 3'd0;
         done_phase = PH_FLAG;
      end else begin
         done_index = index_ff + 3'd1;
         done_phase = PH_TOKEN;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      phase_in = phase_ff;
      index_in = index_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (phase_ff)
                  PH_FLAG: begin
                     cmd.load_flags = 1'b1;
                     index_in       = 3'd0;
                     phase_in       = PH_TOKEN;
                  end
                  PH_TOKEN: begin
                     if (!stat.flag_bits[index_ff]) begin
                        cmd.zero_remain = 1'b1;
                        state_in        = ST_LIT;
                        index_in        = done_index;
                        phase_in        = done_phase;
                     end else begin
                        cmd.load_low = 1'b1;
                        phase_in     = PH_HIGH;
                     end
                  end
                  PH_HIGH: begin
                     cmd.load_hi = 1'b1;
                     if (stat.escape) begin
                        phase_in = PH_LEN;
                     end else begin
                        state_in = ST_RD;
                        index_in = done_index;
                        phase_in = done_phase;
                     end
                  end
                  PH_LEN: begin
                     cmd.load_len = 1'b1;
                     index_in     = done_index;
                     phase_in     = done_phase;
                     if (!stat.len_zero) begin
                        state_in = ST_RD;
                     end
                  end
                  default: begin
                     phase_in = PH_FLAG;
                  end
               endcase
               // A final byte drops any unfinished token and restarts the parser.
               if (stat.fin) begin
                  phase_in = PH_FLAG;
                  index_in = 3'd0;
               end
            end
         end
         ST_LIT: begin
            cmd.lit_put = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_WR;
         end
         ST_WR: begin
            cmd.wr_put = 1'b1;
            if (stat.remain_one || stat.pack_count == PACK_LAST_SLOT) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = stat.remain_zero ? ST_IDLE : ST_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_FLAG;
         index_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         index_ff <= index_in;
      end
   end

   a_emit_ends_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && stat.remain_zero) |=> (state_ff == ST_IDLE))
      else $error("emit of last result did not return to idle");

   a_read_then_write: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_issue |=> (state_ff == ST_WR))
      else $error("history read not followed by its write step");

endmodule

[sv/lzfbd_dpath.sv]
// Datapath: token registers, history ring, byte packing and the result register.
module lzfbd_dpath import lzfbd_pkg::*; #(
   parameter int unsigned WINDOW_DEPTH = 4096
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int unsigned AW = $clog2(WINDOW_DEPTH);
   localparam logic [AW:0] DEPTH_W = (AW + 1)'(WINDOW_DEPTH);
   localparam logic [AW-1:0] WP_LAST = AW'(WINDOW_DEPTH - 1);

   logic [7:0] ring_mem [WINDOW_DEPTH];

   logic [7:0]          flag_bits_ff, flag_bits_in;
   logic [7:0]          low_ff, low_in;
   logic [DIST_BITS-1:0] dist_ff, dist_in;
   logic [7:0]          remain_ff, remain_in;
   logic [7:0]          lit_ff, lit_in;
   logic [AW-1:0]       wp_ff, wp_in;
   logic                full_ff, full_in;
   logic [3:0][7:0]     pack_ff, pack_in;
   logic [2:0]          pack_count_ff, pack_count_in;
   logic [7:0]          rd_data_ff;
   logic                rd_ok_ff;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [15:0]   match_word;
   logic [AW:0]   diff;
   logic [AW:0]   src_wide;
   logic [AW-1:0] src;
   logic          put;
   logic [7:0]    put_byte;

   assign match_word = {req_data.code_byte, low_ff};

   // Ring position of the copy source; distance is below the depth, so one wrap fixes it.
   assign diff     = {1'b0, wp_ff} - {(AW + 1 - DIST_BITS)'(0), dist_ff};
   assign src_wide = diff[AW] ? (diff + DEPTH_W) : diff;
   assign src      = src_wide[AW-1:0];

   assign put      = cmd.lit_put | cmd.wr_put;
   // Until the ring first wraps, entries at or past the write position are read as zeros.
   assign put_byte = cmd.lit_put ? lit_ff : (rd_ok_ff ? rd_data_ff : 8'd0);

   always_comb begin
      stat.flag_bits   = flag_bits_ff;
      stat.escape      = (req_data.code_byte[7:4] == ESC_NIBBLE);
      stat.len_zero    = (req_data.code_byte == 8'd0);
      stat.fin         = req_data.final_byte;
      stat.pack_count  = pack_count_ff;
      stat.remain_one  = (remain_ff == 8'd1);
      stat.remain_zero = (remain_ff == 8'd0);
      stat.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      flag_bits_in  = cmd.load_flags ? req_data.code_byte : flag_bits_ff;
      low_in        = cmd.load_low ? req_data.code_byte : low_ff;
      lit_in        = cmd.accept ? req_data.code_byte : lit_ff;
      dist_in       = dist_ff;
      remain_in     = remain_ff;
      if (cmd.load_hi) begin
         dist_in   = DIST_BITS'(match_word & DIST_MASK);
         remain_in = {4'd0, req_data.code_byte[7:4]} + LEN_BIAS;
      end
      if (cmd.load_len) begin
         remain_in = req_data.code_byte;
      end
      if (cmd.zero_remain) begin
         remain_in = 8'd0;
      end
      if (cmd.wr_put) begin
         remain_in = remain_ff - 8'd1;
      end

      wp_in         = wp_ff;
      full_in       = full_ff;
      pack_in       = pack_ff;
      pack_count_in = pack_count_ff;
      if (put) begin
         pack_in[pack_count_ff[1:0]] = put_byte;
         pack_count_in               = pack_count_ff + 3'd1;
         if (wp_ff == WP_LAST) begin
            wp_in   = '0;
            full_in = 1'b1;
         end else begin
            wp_in = wp_ff + AW'(1);
         end
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      if (cmd.emit) begin
         rsp_in.out_byte0  = pack_ff[0];
         rsp_in.out_byte1  = pack_ff[1];
         rsp_in.out_byte2  = pack_ff[2];
         rsp_in.out_byte3  = pack_ff[3];
         rsp_in.byte_count = pack_count_ff;
         rsp_in.run_end    = (remain_ff == 8'd0);
         rsp_valid_in      = 1'b1;
         pack_in           = '0;
         pack_count_in     = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (put) begin
         ring_mem[wp_ff] <= put_byte;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= ring_mem[src];
         rd_ok_ff   <= full_ff || (src < wp_ff);
      end
   end

   always_ff @(posedge clock) begin
      flag_bits_ff <= flag_bits_in;
      low_ff       <= low_in;
      dist_ff      <= dist_in;
      lit_ff       <= lit_in;
      rsp_ff       <= rsp_in;
      if (reset) begin
         remain_ff     <= 8'd0;
         wp_ff         <= '0;
         full_ff       <= 1'b0;
         pack_ff       <= '0;
         pack_count_ff <= 3'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         remain_ff     <= remain_in;
         wp_ff         <= wp_in;
         full_ff       <= full_in;
         pack_ff       <= pack_in;
         pack_count_ff <= pack_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while still waiting");

   a_rsp_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.byte_count != 3'd0 && rsp_ff.byte_count <= 3'd4))
      else $error("result carries an invalid byte count");

   a_copy_has_bytes: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_put |-> (remain_ff != 8'd0 && pack_count_ff <= PACK_LAST_SLOT))
      else $error("copy byte written with nothing left or a full pack");

   a_pack_bounded: assert property (@(posedge clock) disable iff (reset)
      put |=> (pack_count_ff != 3'd0))
      else $error("pack count lost a byte");

endmodule

[sv/lzss_flag_byte_decompressor.sv]
// Top level of the LZSS flag-byte decompressor: controller plus datapath.
//
//   Channel  Direction  Handshake          Payload
//   req_     in         req_valid/stall    req_type: code_byte, final_byte
//   rsp_     out        rsp_valid/stall    rsp_type: out_byte0..3, byte_count, run_end
//
// A flag byte, a match low byte or the high byte of an escaped match is taken while idle.
// A literal steps through accept, ring write and result load.
// In a match of L bytes each byte is a ring read followed by a ring write, and each
// packed group of up to four takes a result load.
// Reset is synchronous; the ring is not swept, a fill mark makes unwritten entries read zero.
// A stalled result holds the next load; the input stalls while a token is being expanded.
module lzss_flag_byte_decompressor import lzfbd_pkg::*; #(
   parameter int unsigned WINDOW_DEPTH = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   lzfbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   lzfbd_dpath #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[sim/lzss_flag_byte_decompressor_tb.sv]
// Self-checking testbench for the LZSS flag-byte decompressor, with a predictor and random streams.
`timescale 1ns / 1ps

module lzss_flag_byte_decompressor_tb;
   import lzfbd_pkg::*;

   localparam int WINDOW_DEPTH = 4096;
   localparam int QUIET_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 40;

   typedef enum logic [1:0] {
      EXPECT_FLAG,
      EXPECT_TOKEN,
      EXPECT_HIGH,
      EXPECT_LENGTH
   } parse_phase_e;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;
   int error_count = 0;

   // Predictor state: history window, parser and the packing of decoded bytes.
   logic [7:0]   window_mem [WINDOW_DEPTH];
   logic [11:0]  wr_pos = '0;
   logic [7:0]   flags_now = '0;
   logic [2:0]   flag_pos = '0;
   parse_phase_e phase = EXPECT_FLAG;
   logic [7:0]   low_byte = '0;
   logic [11:0]  held_distance = '0;
   int           packed_bytes = 0;
   int           item_chunks = 0;
   rsp_type      expected_chunks [$];

   lzss_flag_byte_decompressor #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Stores one decoded byte and packs it into the newest expected result.
   function automatic void window_put(input logic [7:0] b);
      rsp_type chunk;
      window_mem[wr_pos] = b;
      wr_pos = wr_pos + 12'd1;
      if (packed_bytes == 0) begin
         expected_chunks.push_back('0);
         item_chunks++;
      end
      chunk = expected_chunks[expected_chunks.size() - 1];
      case (packed_bytes)
         0: chunk.out_byte0 = b;
         1: chunk.out_byte1 = b;
         2: chunk.out_byte2 = b;
         default: chunk.out_byte3 = b;
      endcase
      chunk.byte_count = 3'(packed_bytes + 1);
      expected_chunks[expected_chunks.size() - 1] = chunk;
      packed_bytes = (packed_bytes + 1) % 4;
   endfunction

   // Byte-by-byte copy, so an overlapping match repeats what it has just written.
   function automatic void window_copy(input logic [11:0] distance, input int len);
      logic [11:0] src;
      for (int i = 0; i < len; i++) begin
         src = wr_pos - distance;
         window_put(window_mem[src]);
      end
   endfunction

   function automatic void advance_token();
      if (flag_pos == LAST_FLAG) begin
         flag_pos = '0;
         phase = EXPECT_FLAG;
      end else begin
         flag_pos = flag_pos + 3'd1;
         phase = EXPECT_TOKEN;
      end
   endfunction

   function automatic void decode_code_byte(input req_type item);
      logic [15:0] word;
      rsp_type     chunk;
      packed_bytes = 0;
      item_chunks = 0;
      case (phase)
         EXPECT_FLAG: begin
            flags_now = item.code_byte;
            flag_pos = '0;
            phase = EXPECT_TOKEN;
         end
         EXPECT_TOKEN: begin
            if (!flags_now[flag_pos]) begin
               window_put(item.code_byte);
               advance_token();
            end else begin
               low_byte = item.code_byte;
               phase = EXPECT_HIGH;
            end
         end
         EXPECT_HIGH: begin
            word = {item.code_byte, low_byte};
            if (word[15:12] == ESC_NIBBLE) begin
               held_distance = word[11:0];
               phase = EXPECT_LENGTH;
            end else begin
               window_copy(word[11:0], int'(word[15:12]) + int'(LEN_BIAS));
               advance_token();
            end
         end
         default: begin
            window_copy(held_distance, int'(item.code_byte));
            advance_token();
         end
      endcase
      if (item.final_byte) begin
         phase = EXPECT_FLAG;
         flag_pos = '0;
      end
      if (item_chunks > 0) begin
         chunk = expected_chunks[expected_chunks.size() - 1];
         chunk.run_end = 1'b1;
         expected_chunks[expected_chunks.size() - 1] = chunk;
      end
   endfunction

   task automatic report_mismatch(input string what, input int got_val, input int exp_val);
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got_val, exp_val);
      error_count++;
   endtask

   // The expected results are worked out before the transaction is offered;
   // none of them can come back before it is accepted.
   task automatic send_code(input logic [7:0] code, input logic fin);
      req_type item;
      item.code_byte = code;
      item.final_byte = fin;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      decode_code_byte(item);
      items_sent++;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic send_match(input logic [11:0] distance, input int len, input bit escaped,
                             input logic fin);
      logic [7:0] nib_len;
      nib_len = 8'(len) - LEN_BIAS;
      send_code(distance[7:0], 1'b0);
      if (escaped) begin
         send_code({ESC_NIBBLE, distance[11:8]}, 1'b0);
         send_code(8'(len), fin);
      end else begin
         send_code({nib_len[3:0], distance[11:8]}, fin);
      end
   endtask

   // Run of flag groups; the last token carries the final byte, unless a broken run ends it early.
   task automatic send_stream(input int groups, input bit long_only);
      logic [7:0]  flags;
      logic [11:0] distance;
      int          len;
      bit          escaped;
      logic        last;
      for (int g = 0; g < groups; g++) begin
         flags = long_only ? 8'hFF : 8'($urandom_range(255));
         send_code(flags, 1'b0);
         for (int t = 0; t < 8; t++) begin
            last = (g == groups - 1) && (t == 7);
            if (!long_only && $urandom_range(24) == 0) begin
               // Broken run: the final byte lands on the first byte of a token.
               send_code(8'($urandom_range(255)), 1'b1);
               return;
            end
            if (!flags[t]) begin
               send_code(8'($urandom_range(255)), last);
            end else begin
               if (long_only) begin
                  escaped = 1'b1;
                  len = $urandom_range(255, 200);
                  distance = ($urandom_range(3) == 0) ? 12'd0 : 12'($urandom_range(4095));
               end else begin
                  case ($urandom_range(15))
                     0: distance = 12'd0;
                     1: distance = 12'hFFF;
                     2, 3: distance = 12'($urandom_range(4095));
                     default: distance = 12'($urandom_range(40, 1));
                  endcase
                  case ($urandom_range(19))
                     0: begin
                        escaped = 1'b1;
                        len = $urandom_range(255);
                     end
                     1, 2, 3, 4: begin
                        escaped = 1'b1;
                        len = $urandom_range(20);
                     end
                     default: begin
                        escaped = 1'b0;
                        len = $urandom_range(17, 3);
                     end
                  endcase
               end
               send_match(distance, len, escaped, last);
            end
         end
      end
   endtask

   task automatic settle_outputs();
      req_valid <= 1'b0;
      while (expected_chunks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Matches before anything is written read zeros, at distance zero and at the far end.
   task automatic test_unwritten_window();
      idle_pct = 0;
      stall_pct = 0;
      send_code(8'h03, 1'b0);
      send_match(12'h000, 3, 1'b0, 1'b0);
      send_match(12'hFFF, 17, 1'b0, 1'b0);
      send_code(8'hA5, 1'b1);
      settle_outputs();
   endtask

   task automatic test_token_kinds();
      idle_pct = 0;
      stall_pct = 7;
      send_code(8'h1E, 1'b0);
      send_code(8'hFF, 1'b0);
      send_match(12'h001, 18, 1'b1, 1'b0);
      send_match(12'h005, 0, 1'b1, 1'b0);
      send_match(12'h0A5, 255, 1'b1, 1'b0);
      send_match(12'h002, 4, 1'b0, 1'b0);
      send_code(8'h00, 1'b1);
      settle_outputs();
   endtask

   task automatic test_final_byte();
      idle_pct = 7;
      stall_pct = 67;
      send_code(8'h01, 1'b0);
      send_code(8'h34, 1'b1);
      send_code(8'h01, 1'b0);
      send_code(8'h10, 1'b0);
      send_code({ESC_NIBBLE, 4'h0}, 1'b1);
      send_code(8'hFF, 1'b1);
      send_code(8'h01, 1'b0);
      send_match(12'h010, 5, 1'b0, 1'b1);
      settle_outputs();
   endtask

   // Long matches push the write position around the whole window, so that
   // distance zero then reads real data written one window earlier.
   task automatic test_window_wrap();
      idle_pct = 7;
      stall_pct = 7;
      send_stream(3, 1'b1);
      send_stream(2, 1'b0);
      settle_outputs();
   endtask

   task automatic test_random_streams(input int target, input int send_pct, input int rcv_pct);
      int first;
      int n;
      idle_pct = send_pct;
      stall_pct = rcv_pct;
      first = items_sent;
      while (items_sent - first < target) begin
         if ($urandom_range(9) == 0) begin
            n = $urandom_range(5, 1);
            for (int i = 0; i < n; i++)
               send_code(8'($urandom_range(255)),
                         (i == n - 1) ? 1'b1 : logic'($urandom_range(5) == 0));
         end else begin
            send_stream($urandom_range(3, 1), 1'b0);
         end
      end
      settle_outputs();
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chunks.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_data.byte_count, 0);
         end else begin
            want = expected_chunks.pop_front();
            if (rsp_data.out_byte0 !== want.out_byte0)
               report_mismatch("out_byte0", rsp_data.out_byte0, want.out_byte0);
            if (rsp_data.out_byte1 !== want.out_byte1)
               report_mismatch("out_byte1", rsp_data.out_byte1, want.out_byte1);
            if (rsp_data.out_byte2 !== want.out_byte2)
               report_mismatch("out_byte2", rsp_data.out_byte2, want.out_byte2);
            if (rsp_data.out_byte3 !== want.out_byte3)
               report_mismatch("out_byte3", rsp_data.out_byte3, want.out_byte3);
            if (rsp_data.byte_count !== want.byte_count)
               report_mismatch("byte_count", rsp_data.byte_count, want.byte_count);
            if (rsp_data.run_end !== want.run_end)
               report_mismatch("run_end", rsp_data.run_end, want.run_end);
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, expected_chunks.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      for (int i = 0; i < WINDOW_DEPTH; i++)
         window_mem[i] = 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_unwritten_window();
      test_token_kinds();
      test_final_byte();
      test_window_wrap();
      test_random_streams(80, 0, 0);
      test_random_streams(80, 67, 0);
      test_random_streams(80, 0, 67);
      test_random_streams(80, 7, 7);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
